/* rtl/iso9660_root_file_finder_assert.svh */
// Assertion macros for the root file finder.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef ISO9660_ROOT_FILE_FINDER_ASSERT_SVH
`define ISO9660_ROOT_FILE_FINDER_ASSERT_SVH
`ifndef ASSERT_OFF
`define RFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RFF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RFF_ASSERT_IMP(lbl, ante, cons, msg)
`define RFF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/isorff_pkg.sv */
// Shared constants, types and the target name table of the root file finder.
// No dependencies.
package isorff_pkg;

  localparam int SECTOR_BYTES    = 2048;
  localparam int ADDR_W          = $clog2(SECTOR_BYTES);
  // Offsets can run past the sector end by up to one record length.
  localparam int OFF_W           = $clog2(SECTOR_BYTES + 256);

  localparam int REC_HDR_LEN     = 33;
  localparam int REC_FLAGS_POS   = 25;
  localparam int REC_NAMELEN_POS = 32;
  localparam int REC_EXTENT_POS  = 2;
  localparam int FLAG_DIR_BIT    = 1;
  localparam int TARGET_LEN      = 10;
  localparam int LBA_BYTES       = 4;
  localparam int IDX_W           = 4;

  typedef enum logic [2:0] {
    STOP_FOUND        = 3'd0,
    STOP_ZERO_LEN     = 3'd1,
    STOP_NAME_OVERRUN = 3'd2,
    STOP_SECTOR_END   = 3'd3,
    STOP_ZERO_ADDR    = 3'd4
  } stop_t;

  typedef enum logic [2:0] {
    RA_LEN,
    RA_FLAGS,
    RA_NLEN,
    RA_NAME,
    RA_LBA
  } rd_sel_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_REC,
    ST_LEN,
    ST_FLAGS,
    ST_NLEN,
    ST_NAME,
    ST_LBA
  } state_t;

  typedef struct packed {
    logic    load_wr;
    logic    off_clear;
    logic    off_advance;
    logic    len_ld;
    logic    flags_ld;
    logic    idx_clear;
    logic    idx_inc;
    logic    lba_shift;
    logic    finish;
    stop_t   reason;
    rd_sel_t rd_sel;
  } cmd_t;

  typedef struct packed {
    logic last_byte;
    logic out_pending;
    logic hdr_fits;
    logic len_zero;
    logic name_overrun;
    logic name_cand;
    logic name_match;
    logic name_last;
    logic lba_last;
    logic lba_nonzero;
  } status_t;

  // Bytes of "SYSTEM.CNF".
  function automatic logic [7:0] target_byte(input logic [IDX_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      4'd0:    b = 8'h53;
      4'd1:    b = 8'h59;
      4'd2:    b = 8'h53;
      4'd3:    b = 8'h54;
      4'd4:    b = 8'h45;
      4'd5:    b = 8'h4D;
      4'd6:    b = 8'h2E;
      4'd7:    b = 8'h43;
      4'd8:    b = 8'h4E;
      4'd9:    b = 8'h46;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* rtl/isorff_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module isorff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/isorff_ctrl.sv */
// Controller: sequences sector loading and the directory record walk.
// Depends on isorff_pkg.
module isorff_ctrl
  import isorff_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    cmd.reason = STOP_SECTOR_END;
    cmd.rd_sel = RA_LEN;
    in_ready   = 1'b0;
    case (state_r)
      ST_LOAD: begin
        // The last byte waits until the previous result has been taken.
        in_ready = !(status.last_byte && status.out_pending);
        if (in_valid && in_ready) begin
          cmd.load_wr = 1'b1;
          if (status.last_byte) begin
            cmd.off_clear = 1'b1;
            state_nxt     = ST_REC;
          end
        end
      end
      ST_REC: begin
        if (!status.hdr_fits) begin
          cmd.finish = 1'b1;
          cmd.reason = STOP_SECTOR_END;
          state_nxt  = ST_LOAD;
        end else begin
          cmd.rd_sel = RA_LEN;
          state_nxt  = ST_LEN;
        end
      end
      ST_LEN: begin
        if (status.len_zero) begin
          cmd.finish = 1'b1;
          cmd.reason = STOP_ZERO_LEN;
          state_nxt  = ST_LOAD;
        end else begin
          cmd.len_ld = 1'b1;
          cmd.rd_sel = RA_FLAGS;
          state_nxt  = ST_FLAGS;
        end
      end
      ST_FLAGS: begin
        cmd.flags_ld = 1'b1;
        cmd.rd_sel   = RA_NLEN;
        state_nxt    = ST_NLEN;
      end
      ST_NLEN: begin
        if (status.name_overrun) begin
          cmd.finish = 1'b1;
          cmd.reason = STOP_NAME_OVERRUN;
          state_nxt  = ST_LOAD;
        end else if (status.name_cand) begin
          cmd.idx_clear = 1'b1;
          cmd.rd_sel    = RA_NAME;
          state_nxt     = ST_NAME;
        end else begin
          cmd.off_advance = 1'b1;
          state_nxt       = ST_REC;
        end
      end
      ST_NAME: begin
        if (!status.name_match) begin
          cmd.off_advance = 1'b1;
          state_nxt       = ST_REC;
        end else if (status.name_last) begin
          cmd.idx_clear = 1'b1;
          cmd.rd_sel    = RA_LBA;
          state_nxt     = ST_LBA;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.rd_sel  = RA_NAME;
        end
      end
      ST_LBA: begin
        cmd.lba_shift = 1'b1;
        if (status.lba_last) begin
          cmd.finish = 1'b1;
          cmd.reason = status.lba_nonzero ? STOP_FOUND : STOP_ZERO_ADDR;
          state_nxt  = ST_LOAD;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.rd_sel  = RA_LBA;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

/* rtl/isorff_dp.sv */
// Datapath: sector store, record offset, field registers and result register.
// Depends on isorff_pkg and isorff_ram.
module isorff_dp
  import isorff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_data_byte,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic        out_ready,
  output logic        out_valid,
  output logic        out_found,
  output logic [31:0] out_file_lba,
  output logic [2:0]  out_stop_reason
);

  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [7:0]        len_r;
  logic [7:0]        flags_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [31:0]       lba_r;
  logic              out_valid_r;
  logic              out_found_r;
  logic [31:0]       out_lba_r;
  logic [2:0]        out_reason_r;

  logic [OFF_W-1:0]  rd_off;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rdata;
  logic [31:0]       lba_full;
  logic              is_found;

  isorff_ram #(
    .WIDTH(8),
    .DEPTH(SECTOR_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (cnt_r),
    .wdata (in_data_byte),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load_wr) begin
      cnt_nxt = (cnt_r == ADDR_W'(SECTOR_BYTES - 1)) ? '0 : cnt_r + ADDR_W'(1);
    end
    off_nxt = off_r;
    if (cmd.off_clear) begin
      off_nxt = '0;
    end else if (cmd.off_advance) begin
      off_nxt = off_r + OFF_W'(len_r);
    end
    idx_nxt = idx_r;
    if (cmd.idx_clear) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  // The address for the byte needed next uses the index of the next cycle.
  always_comb begin
    case (cmd.rd_sel)
      RA_LEN:   rd_off = off_r;
      RA_FLAGS: rd_off = off_r + OFF_W'(REC_FLAGS_POS);
      RA_NLEN:  rd_off = off_r + OFF_W'(REC_NAMELEN_POS);
      RA_NAME:  rd_off = off_r + OFF_W'(REC_HDR_LEN) + OFF_W'(idx_nxt);
      RA_LBA:   rd_off = off_r + OFF_W'(REC_EXTENT_POS) + OFF_W'(idx_nxt);
      default:  rd_off = off_r;
    endcase
  end

  assign rd_addr  = rd_off[ADDR_W-1:0];
  assign lba_full = {rdata, lba_r[31:8]};
  assign is_found = (cmd.reason == STOP_FOUND);

  always_comb begin
    status.last_byte    = (cnt_r == ADDR_W'(SECTOR_BYTES - 1));
    status.out_pending  = out_valid_r;
    status.hdr_fits     = (off_r + OFF_W'(REC_HDR_LEN)) < OFF_W'(SECTOR_BYTES);
    status.len_zero     = (rdata == 8'd0);
    status.name_overrun = (off_r + OFF_W'(REC_HDR_LEN) + OFF_W'(rdata))
                          > OFF_W'(SECTOR_BYTES);
    status.name_cand    = !flags_r[FLAG_DIR_BIT] && (rdata >= 8'(TARGET_LEN));
    status.name_match   = (rdata == target_byte(idx_r));
    status.name_last    = (idx_r == IDX_W'(TARGET_LEN - 1));
    status.lba_last     = (idx_r == IDX_W'(LBA_BYTES - 1));
    status.lba_nonzero  = (lba_full != 32'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      off_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      off_r <= off_nxt;
      idx_r <= idx_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.len_ld) begin
      len_r <= rdata;
    end
    if (cmd.flags_ld) begin
      flags_r <= rdata;
    end
    if (cmd.lba_shift) begin
      lba_r <= lba_full;
    end
    if (cmd.finish) begin
      out_found_r  <= is_found;
      out_lba_r    <= is_found ? lba_full : 32'd0;
      out_reason_r <= cmd.reason;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_file_lba    = out_lba_r;
  assign out_stop_reason = out_reason_r;

endmodule

/* rtl/iso9660_root_file_finder.sv */
// Root file finder top level: controller plus datapath with the sector store.
// Depends on isorff_pkg, isorff_ctrl, isorff_dp and the assertion macro header.

// The block takes one directory sector of SECTOR_BYTES items, one byte per
// cycle when in_valid and in_ready are both high, then walks its directory
// records from offset 0 looking for a file named SYSTEM.CNF and delivers
// exactly one result per sector. The walk reads the sector store through its
// single read port one byte a cycle: it stops at the sector end when no record
// header fits, and per record reads length, flags and name length, then
// compares the name and, for a match, reads the extent address. Input is
// refused during the walk. The next sector may load while a result waits on
// the output; only its last byte waits until that result has been taken.
module iso9660_root_file_finder
  import isorff_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [31:0] out_file_lba,
  output logic [2:0]  out_stop_reason
);

`include "iso9660_root_file_finder_assert.svh"

  cmd_t    cmd;
  status_t status;

  isorff_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  isorff_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .status          (status),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_found       (out_found),
    .out_file_lba    (out_file_lba),
    .out_stop_reason (out_stop_reason)
  );

  `RFF_ASSERT_IMP(a_no_overwrite, cmd.finish, !out_valid, "walk finished over a pending result")
  `RFF_ASSERT_NEXT(a_finish_shows, cmd.finish, out_valid, "finished walk gave no result")
  `RFF_ASSERT_IMP(a_found_lba, out_valid && out_found, out_file_lba != 32'd0, "found with zero address")
  `RFF_ASSERT_IMP(a_found_code, out_valid, out_found == (out_stop_reason == STOP_FOUND), "found flag and stop reason disagree")

endmodule
